// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL files.
// Each check is sampled on the rising edge of clk_i and is off while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition implies the expression in the same cycle.
`define ASSERT_NOW(label, cond, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (expr)) \
    else $error(msg);

// The condition implies the expression in the next cycle.
`define ASSERT_NEXT(label, cond, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (expr)) \
    else $error(msg);

`endif

// ===== rtl/bb3_pkg.sv =====
package bb3_pkg;

  // Pixel layout: channel 0 is red, 1 is green, 2 is blue, red in the lowest byte.
  localparam int NUM_CH = 3;
  localparam int CH_W   = 8;
  localparam int PIX_W  = NUM_CH * CH_W;
  localparam int CH_MAX = 255;

  // Configuration registers.
  localparam int CFG_W_BITS = 11;
  localparam int CFG_H_BITS = 13;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

  localparam logic [CFG_W_BITS-1:0] FRAME_WIDTH_RESET  = 11'd1024;
  localparam logic [CFG_H_BITS-1:0] FRAME_HEIGHT_RESET = 13'd768;

  // Defaults of the top level parameters.
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 4096;

  // Sum widths: top plus middle of one column, then sums over up to three columns.
  localparam int TM_W  = CH_W + 1;
  localparam int TMS_W = TM_W + 2;
  localparam int BTS_W = CH_W + 2;
  localparam int ACC_W = 12;

  // Division by 4, 6 or 9 as a multiply by a scaled reciprocal. For sums below
  // 4096 the truncated product equals the exact quotient.
  localparam int RECIP_SHIFT = 16;
  localparam int RECIP_W     = 15;
  localparam int RECIP_4     = 2 ** (RECIP_SHIFT - 2);
  localparam int RECIP_6     = (2 ** RECIP_SHIFT + 5) / 6;
  localparam int RECIP_9     = (2 ** RECIP_SHIFT + 8) / 9;

  // Queue between the front and the back.
  localparam int QUEUE_DEPTH = 4;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    DIV_4,
    DIV_6,
    DIV_9
  } div_e;

  // One averaging job as handed from the front to the back.
  typedef struct packed {
    logic [NUM_CH-1:0][TMS_W-1:0] tm_sum;
    logic [NUM_CH-1:0][BTS_W-1:0] bt_sum;
    div_e                         div;
    logic                         last;
  } job_t;

  function automatic logic [RECIP_W-1:0] recip_of(div_e div);
    logic [RECIP_W-1:0] res;
    unique case (div)
      DIV_4:   res = RECIP_W'(RECIP_4);
      DIV_6:   res = RECIP_W'(RECIP_6);
      DIV_9:   res = RECIP_W'(RECIP_9);
      default: res = '0;
    endcase
    return res;
  endfunction

  // Half the divisor, rounded down, for round-half-up.
  function automatic logic [2:0] half_of(div_e div);
    logic [2:0] res;
    unique case (div)
      DIV_4:   res = 3'd2;
      DIV_6:   res = 3'd3;
      DIV_9:   res = 3'd4;
      default: res = '0;
    endcase
    return res;
  endfunction

endpackage

// ===== rtl/bb3_fifo.sv =====
`include "assert_macros.svh"

module bb3_fifo #(
  parameter int  DEPTH = bb3_pkg::QUEUE_DEPTH,
  parameter type T     = bb3_pkg::job_t
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  T                           data_i,
  input  logic                       pop_i,
  output T                           data_o,
  output logic                       valid_o,
  output logic [$clog2(DEPTH+1)-1:0] count_o
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  T                   mem_q [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]   count_q;

  assign data_o  = mem_q[rd_ptr_q];
  assign valid_o = (count_q != '0);
  assign count_o = count_q;

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      unique case ({push_i, pop_i})
        2'b10:   count_q <= count_q + CNT_W'(1);
        2'b01:   count_q <= count_q - CNT_W'(1);
        default: count_q <= count_q;
      endcase
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  `ASSERT_NOW(FifoNoOverflow, push_i, count_q < CNT_W'(DEPTH), "push into a full queue")
  `ASSERT_NOW(FifoNoUnderflow, pop_i, count_q != '0, "pop from an empty queue")

endmodule

// ===== rtl/bb3_front.sv =====
`include "assert_macros.svh"

module bb3_front #(
  parameter int MAX_WIDTH  = bb3_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = bb3_pkg::DEF_MAX_HEIGHT
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [bb3_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [bb3_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic                            s_tvalid_i,
  output logic                            s_tready_o,
  input  logic [bb3_pkg::PIX_W-1:0]       s_tdata_i,
  input  logic [bb3_pkg::CNT_W-1:0]       q_count_i,
  output logic                            push_o,
  output bb3_pkg::job_t                   job_o
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int WC_W  = COL_W + 1;
  localparam int WX_W  = (WC_W > bb3_pkg::CFG_W_BITS) ? WC_W : bb3_pkg::CFG_W_BITS;
  localparam int ROW_W = $clog2(MAX_HEIGHT + 2);
  localparam int HX_W  = (ROW_W > bb3_pkg::CFG_H_BITS) ? ROW_W : bb3_pkg::CFG_H_BITS;
  localparam int CRD_W = $clog2(bb3_pkg::QUEUE_DEPTH + 3);
  localparam int NCH   = bb3_pkg::NUM_CH;
  localparam int CHW   = bb3_pkg::CH_W;

  // What one item does, decided from its position when it is accepted.
  typedef struct packed {
    logic          top_ok;
    logic          bot_ok;
    logic          left_ok;
    logic          emit_edge;
    logic          emit_int;
    bb3_pkg::div_e div;
    logic          last;
  } cls_t;

  logic [bb3_pkg::CFG_W_BITS-1:0] frame_width_q;
  logic [bb3_pkg::CFG_H_BITS-1:0] frame_height_q;
  logic [WX_W-1:0]                w_ext;
  logic [HX_W-1:0]                h_ext;
  logic [WC_W-1:0]                w_c;
  logic [ROW_W-1:0]               h_c;

  logic [COL_W-1:0] col_q, col_d, c;
  logic [ROW_W-1:0] row_q, row_d, r;
  logic [WC_W-1:0]  c_ext, c_next;
  logic             accept;
  logic             rows3;
  cls_t             cls_d;

  logic [CRD_W-1:0] credit;

  logic [bb3_pkg::PIX_W-1:0] store_mid [MAX_WIDTH];
  logic [bb3_pkg::PIX_W-1:0] store_top [MAX_WIDTH];
  logic [bb3_pkg::PIX_W-1:0] mid_rd_q, top_rd_q;

  logic                      f1_valid_q;
  cls_t                      f1_q;
  logic [bb3_pkg::PIX_W-1:0] f1_pix_q;
  logic [COL_W-1:0]          f1_col_q;
  logic                      f2_valid_q;
  cls_t                      f2_q;

  logic [NCH-1:0][bb3_pkg::TM_W-1:0]  tm_new;
  logic [2:0][NCH-1:0][bb3_pkg::TM_W-1:0] tm_q;
  logic [2:0][NCH-1:0][CHW-1:0]        bt_q;
  logic [NCH-1:0][bb3_pkg::TMS_W-1:0] tm_sum;
  logic [NCH-1:0][bb3_pkg::BTS_W-1:0] bt_sum;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= bb3_pkg::FRAME_WIDTH_RESET;
      frame_height_q <= bb3_pkg::FRAME_HEIGHT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bb3_pkg::REG_FRAME_WIDTH:  frame_width_q  <= cfg_wdata_i[bb3_pkg::CFG_W_BITS-1:0];
        bb3_pkg::REG_FRAME_HEIGHT: frame_height_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Clamp the frame size to what the row stores and counters support.
  always_comb begin
    w_ext = WX_W'(frame_width_q);
    if (w_ext < WX_W'(2)) begin
      w_ext = WX_W'(2);
    end else if (w_ext > WX_W'(MAX_WIDTH)) begin
      w_ext = WX_W'(MAX_WIDTH);
    end
    w_c = WC_W'(w_ext);

    h_ext = HX_W'(frame_height_q);
    if (h_ext < HX_W'(2)) begin
      h_ext = HX_W'(2);
    end else if (h_ext > HX_W'(MAX_HEIGHT)) begin
      h_ext = HX_W'(MAX_HEIGHT);
    end
    h_c = ROW_W'(h_ext);
  end

  // Accept only while the queue has room for every item still in flight.
  assign credit = CRD_W'(q_count_i) + CRD_W'(f1_valid_q) + CRD_W'(f2_valid_q);
  assign s_tready_o = (credit < CRD_W'(bb3_pkg::QUEUE_DEPTH));
  assign accept = s_tvalid_i && s_tready_o;

  // Position of this item and its role. A column beyond a narrowed width wraps first.
  always_comb begin
    if ({1'b0, col_q} >= w_c) begin
      c = '0;
      r = row_q + ROW_W'(1);
    end else begin
      c = col_q;
      r = row_q;
    end
    c_ext = {1'b0, c};

    cls_d.top_ok    = (r >= ROW_W'(2));
    cls_d.left_ok   = (c_ext >= WC_W'(2));
    cls_d.emit_edge = (c == '0) && (r >= ROW_W'(2));
    cls_d.emit_int  = (c != '0) && (r != '0);
    cls_d.last      = cls_d.emit_edge && (r > h_c);
    rows3           = (r >= ROW_W'(2)) && (r < h_c);

    // The edge result belongs to the previous row, the inner one to this row.
    if (cls_d.emit_edge) begin
      cls_d.bot_ok = (r <= h_c);
      cls_d.div    = ((r >= ROW_W'(3)) && (r <= h_c)) ? bb3_pkg::DIV_6 : bb3_pkg::DIV_4;
    end else begin
      cls_d.bot_ok = (r < h_c);
      if (rows3 && cls_d.left_ok) begin
        cls_d.div = bb3_pkg::DIV_9;
      end else if (rows3 || cls_d.left_ok) begin
        cls_d.div = bb3_pkg::DIV_6;
      end else begin
        cls_d.div = bb3_pkg::DIV_4;
      end
    end

    // Next position; the last drain item after a frame restarts both counters.
    c_next = c_ext + WC_W'(1);
    if (cls_d.last) begin
      col_d = '0;
      row_d = '0;
    end else if (c_next >= w_c) begin
      col_d = '0;
      row_d = r + ROW_W'(1);
    end else begin
      col_d = c_next[COL_W-1:0];
      row_d = r;
    end
  end

  // Position counters and stage valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      f1_valid_q <= 1'b0;
      f2_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        col_q <= col_d;
        row_q <= row_d;
      end
      f1_valid_q <= accept;
      f2_valid_q <= f1_valid_q;
    end
  end

  // Stage payloads.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      f1_q     <= cls_d;
      f1_pix_q <= s_tdata_i;
      f1_col_q <= c;
    end
    if (f1_valid_q) begin
      f2_q <= f1_q;
    end
  end

  // Row stores: read at accept, written back in the next cycle at the same column.
  // A same-column read and write in the same cycle only happens right after a frame end,
  // where the value read lies outside every later neighborhood.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mid_rd_q <= store_mid[c];
    end
    if (f1_valid_q) begin
      store_mid[f1_col_q] <= f1_pix_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      top_rd_q <= store_top[c];
    end
    if (f1_valid_q) begin
      store_top[f1_col_q] <= mid_rd_q;
    end
  end

  // Partial sum of the new column: top row masked by the row position.
  always_comb begin
    for (int ch = 0; ch < NCH; ch++) begin
      tm_new[ch] = (f1_q.top_ok ? bb3_pkg::TM_W'(top_rd_q[ch*CHW +: CHW])
                                : '0) + bb3_pkg::TM_W'(mid_rd_q[ch*CHW +: CHW]);
    end
  end

  // Column window: top+middle sums and bottom pixels of the last three columns.
  always_ff @(posedge clk_i) begin
    if (f1_valid_q) begin
      tm_q[0] <= tm_q[1];
      tm_q[1] <= tm_q[2];
      tm_q[2] <= tm_new;
      bt_q[0] <= bt_q[1];
      bt_q[1] <= bt_q[2];
      bt_q[2] <= f1_pix_q;
    end
  end

  // Sums over the selected columns; the bottom row is masked by the current height.
  always_comb begin
    for (int ch = 0; ch < NCH; ch++) begin
      if (f2_q.emit_edge) begin
        tm_sum[ch] = bb3_pkg::TMS_W'(tm_q[0][ch]) + bb3_pkg::TMS_W'(tm_q[1][ch]);
        bt_sum[ch] = bb3_pkg::BTS_W'(bt_q[0][ch]) + bb3_pkg::BTS_W'(bt_q[1][ch]);
      end else begin
        tm_sum[ch] = (f2_q.left_ok ? bb3_pkg::TMS_W'(tm_q[0][ch]) : '0)
                   + bb3_pkg::TMS_W'(tm_q[1][ch]) + bb3_pkg::TMS_W'(tm_q[2][ch]);
        bt_sum[ch] = (f2_q.left_ok ? bb3_pkg::BTS_W'(bt_q[0][ch]) : '0)
                   + bb3_pkg::BTS_W'(bt_q[1][ch]) + bb3_pkg::BTS_W'(bt_q[2][ch]);
      end
      if (!f2_q.bot_ok) begin
        bt_sum[ch] = '0;
      end
    end
  end

  assign push_o        = f2_valid_q && (f2_q.emit_edge || f2_q.emit_int);
  assign job_o.tm_sum  = tm_sum;
  assign job_o.bt_sum  = bt_sum;
  assign job_o.div     = f2_q.div;
  assign job_o.last    = f2_q.last;

  `ASSERT_NEXT(FrontLastRestarts, accept && cls_d.last, col_q == '0 && row_q == '0,
               "frame end did not restart the position counters")

endmodule

// ===== rtl/bb3_back.sv =====
`include "assert_macros.svh"

module bb3_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      q_valid_i,
  input  bb3_pkg::job_t             job_i,
  output logic                      pop_o,
  output logic                      m_tvalid_o,
  input  logic                      m_tready_i,
  output logic [bb3_pkg::PIX_W-1:0] m_tdata_o,
  output logic                      m_tlast_o
);

  localparam int NCH    = bb3_pkg::NUM_CH;
  localparam int CHW    = bb3_pkg::CH_W;
  localparam int PROD_W = bb3_pkg::ACC_W + bb3_pkg::RECIP_W;
  localparam int QUO_W  = PROD_W - bb3_pkg::RECIP_SHIFT;

  logic                               b1_valid_q;
  logic [NCH-1:0][bb3_pkg::ACC_W-1:0] b1_x_q, x_d;
  bb3_pkg::div_e                      b1_div_q;
  logic                               b1_last_q;
  logic                               out_free, b1_ready;

  logic [NCH-1:0][PROD_W-1:0]         prod;
  logic [NCH-1:0][QUO_W-1:0]          quo;
  logic [NCH-1:0][CHW-1:0]            res;
  logic [bb3_pkg::RECIP_W-1:0]        recip;

  logic                               out_valid_q;
  logic [NCH-1:0][CHW-1:0]            out_data_q;
  logic                               out_last_q;

  // Two stages with ready chaining: rounding add, then reciprocal multiply.
  assign out_free = !out_valid_q || m_tready_i;
  assign b1_ready = !b1_valid_q || out_free;
  assign pop_o    = q_valid_i && b1_ready;

  always_comb begin
    for (int ch = 0; ch < NCH; ch++) begin
      x_d[ch] = bb3_pkg::ACC_W'(job_i.tm_sum[ch]) + bb3_pkg::ACC_W'(job_i.bt_sum[ch])
              + bb3_pkg::ACC_W'(bb3_pkg::half_of(job_i.div));
    end
  end

  // Quotient by reciprocal; the clamp only guards the channel range.
  assign recip = bb3_pkg::recip_of(b1_div_q);
  always_comb begin
    for (int ch = 0; ch < NCH; ch++) begin
      prod[ch] = PROD_W'(b1_x_q[ch]) * PROD_W'(recip);
      quo[ch]  = prod[ch][bb3_pkg::RECIP_SHIFT +: QUO_W];
      res[ch]  = (quo[ch] > QUO_W'(bb3_pkg::CH_MAX)) ? CHW'(bb3_pkg::CH_MAX)
                                                     : quo[ch][CHW-1:0];
    end
  end

  // Valid bits of both stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (b1_ready) begin
        b1_valid_q <= pop_o;
      end
      if (out_free) begin
        out_valid_q <= b1_valid_q;
      end
    end
  end

  // Stage payloads.
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      b1_x_q    <= x_d;
      b1_div_q  <= job_i.div;
      b1_last_q <= job_i.last;
    end
    if (b1_valid_q && out_free) begin
      out_data_q <= res;
      out_last_q <= b1_last_q;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = out_data_q;
  assign m_tlast_o  = out_last_q;

  `ASSERT_NEXT(BackPopLoadsStage, pop_o, b1_valid_q, "popped job did not reach the rounding stage")

endmodule

// ===== rtl/box_blur_3x3_rgb_core.sv =====
// 3x3 box blur of an RGB frame streamed in raster order.
// Input channel: one pixel per transfer on s_tdata_i; s_tuser_i carries the drain
// flag of the source, but the block takes an item's role from its position alone.
// After the last pixel of a frame the source sends frame_width+1 drain items.
// Output channel: one blurred pixel per transfer on m_tdata_o, m_tlast_o marks the
// last pixel of a frame. Output pixel (row, col) is produced by the input item
// one row and one column later, that is frame_width+1 items behind.
// A result passes the front stages f1 and f2, the queue, the rounding stage and the output register.
// Throughput: one item per cycle while the receiver accepts, limited by the single read port of each row store.
// The front registers the position, reads both row stores and sums columns; a
// four-entry queue feeds the back, which rounds and divides by 4, 6 or 9.
// Configuration: cfg_we_i writes frame_width (index 0) or frame_height (index 1);
// write only while no items are in flight. Values are clamped to the supported range.
// Reset: counters restart at the frame origin, size returns to 1024x768; row stores
// are not cleared, their unwritten entries never reach a result.
// Receiver stall: the output register holds, the queue fills and s_tready_o drops.
module box_blur_3x3_rgb_core #(
  parameter int MAX_WIDTH  = bb3_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = bb3_pkg::DEF_MAX_HEIGHT
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [bb3_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [bb3_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic                            s_tvalid_i,
  output logic                            s_tready_o,
  input  logic [bb3_pkg::PIX_W-1:0]       s_tdata_i,   // in_red, in_green, in_blue
  input  logic [0:0]                      s_tuser_i,   // flush
  output logic                            m_tvalid_o,
  input  logic                            m_tready_i,
  output logic [bb3_pkg::PIX_W-1:0]       m_tdata_o,   // out_red, out_green, out_blue
  output logic                            m_tlast_o
);

  logic                         push;
  logic                         pop;
  logic                         q_valid;
  logic [bb3_pkg::CNT_W-1:0]    q_count;
  bb3_pkg::job_t                job_in, job_out;

  bb3_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .s_tvalid_i  (s_tvalid_i),
    .s_tready_o  (s_tready_o),
    .s_tdata_i   (s_tdata_i),
    .q_count_i   (q_count),
    .push_o      (push),
    .job_o       (job_in)
  );

  bb3_fifo #(
    .DEPTH (bb3_pkg::QUEUE_DEPTH),
    .T     (bb3_pkg::job_t)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (job_in),
    .pop_i   (pop),
    .data_o  (job_out),
    .valid_o (q_valid),
    .count_o (q_count)
  );

  bb3_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .job_i      (job_out),
    .pop_o      (pop),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o),
    .m_tlast_o  (m_tlast_o)
  );

endmodule
